// File: src/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants of the best-fit block pool: field widths,
// request modes, result codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package bfp_pkg;

    // Field widths
    localparam int ADDR_W    = 40;
    localparam int SIZE_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 40;

    // Stream payloads, padded to whole bytes
    localparam int S_FIELDS_W = MODE_W + SIZE_W + ADDR_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 4 * ADDR_W + STATUS_W + 2 * COUNT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Table depth default
    localparam int DEF_MAX_ENTRIES = 16;

    // Register reset values
    localparam logic [SIZE_W-1:0] POOL_SIZE_RST    = 32'd67108864;
    localparam logic [ADDR_W-1:0] REGION_BASE_RST  = 40'd4096;
    localparam logic [ADDR_W-1:0] REGION_LIMIT_RST = 40'hFF_FFFF_FFFF;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT = 2'd2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GROWN    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GROW,
        S_TAKE,
        S_FREE,
        S_OUT
    } t_state;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic clear;      // start a new search
        logic cmp_vld;    // read data holds an entry to compare
        logic cmp_busy;   // in-use mark of that entry
        logic free_mode;  // match on base of a busy entry instead of best fit
    } t_scan_ctl;

endpackage

// File: src/best_fit_block_pool_unit.sv
// ----------------------------------------------------------------------------
// best_fit_block_pool_unit
// Best-fit allocator over a table of whole pool blocks with a bump pointer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the slave stream (tdata: mode, request_bytes,
//   free_address). Each request gives exactly one result on the master stream
//   (granted_address, status, byte totals, grant and release counts).
//   Configuration (pool_size, region_base, region_limit) must be written
//   through the plain write port only while the block is idle; the block
//   itself does not enforce this. An allocate or free reads the entry
//   table once, one entry per cycle through the table memory port and the
//   shared compare unit, then takes a block, grows the pool or frees the
//   match before the result is presented and tready is high again; growth
//   replaces the take step. A reset request goes straight to the growth
//   step and an unused mode straight to the result. One request is in flight
//   at a time; tready is low meanwhile.
//   The result sits in an output register, so the next request is taken
//   while it waits; a stalled receiver holds the block in its final step
//   once a second result is ready.
//   Synchronous reset empties the table, zeroes totals and counts, and loads
//   the register defaults; no seed block exists until a reset request.
// ----------------------------------------------------------------------------
module best_fit_block_pool_unit #(
    parameter int MAX_ENTRIES = bfp_pkg::DEF_MAX_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Requests
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [1:0] mode, [33:2] request_bytes, [73:34] free_address
    input  logic [bfp_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // Results
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [39:0] granted_address, [42:40] status, [82:43] bytes_total,
    // [122:83] bytes_used, [162:123] bytes_free, [194:163] grant_count,
    // [226:195] release_count
    output logic [bfp_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    // Configuration
    input  logic                          i_cfg_wr_en,
    input  logic [bfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfp_pkg::CFG_W-1:0]     i_cfg_data
);
    import bfp_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = ADDR_W + SIZE_W;
    localparam int PAD_W = M_DATA_W - M_FIELDS_W;

    // Configuration registers
    logic [SIZE_W-1:0] r_pool_size;
    logic [ADDR_W-1:0] r_region_base;
    logic [ADDR_W-1:0] r_region_limit;

    // Request registers
    logic [MODE_W-1:0] r_mode;
    logic [SIZE_W-1:0] r_want;
    logic [ADDR_W-1:0] r_addr;

    // Sequencer and pool state
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_idx, n_cmp_idx;
    logic [MAX_ENTRIES-1:0] r_busy, n_busy;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [ADDR_W-1:0]      r_bump, n_bump;
    logic [ADDR_W-1:0]      r_total, n_total;
    logic [ADDR_W-1:0]      r_used, n_used;
    logic [ADDR_W-1:0]      r_free, n_free;
    logic [COUNT_W-1:0]     r_grants, n_grants;
    logic [COUNT_W-1:0]     r_releases, n_releases;
    logic [ADDR_W-1:0]      r_granted, n_granted;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic                   r_m_valid, n_m_valid;
    logic [M_DATA_W-1:0]    r_m_data, n_m_data;

    // Entry table
    logic [ENT_W-1:0] r_mem [MAX_ENTRIES];
    logic [ENT_W-1:0] r_rd;
    logic             w_mem_we;

    // Scan unit
    t_scan_ctl         w_scan_ctl;
    logic              w_found;
    logic [IDX_W-1:0]  w_pick_idx;
    logic [ADDR_W-1:0] w_pick_base;
    logic [SIZE_W-1:0] w_pick_size;

    logic              w_s_accept;
    logic              w_scan_more;
    logic [SIZE_W-1:0] w_half;
    logic [SIZE_W-1:0] w_grow_size;
    logic [ADDR_W:0]   w_grow_end;
    logic              w_grow_ok;

    assign w_s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size    <= POOL_SIZE_RST;
            r_region_base  <= REGION_BASE_RST;
            r_region_limit <= REGION_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_POOL_SIZE:    r_pool_size    <= i_cfg_data[SIZE_W-1:0];
                CFG_REGION_BASE:  r_region_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_REGION_LIMIT: r_region_limit <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_mode <= i_s_axis_tdata[MODE_W-1:0];
            r_want <= i_s_axis_tdata[MODE_W +: SIZE_W];
            r_addr <= i_s_axis_tdata[MODE_W+SIZE_W +: ADDR_W];
        end
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[IDX_W-1:0]] <= {r_bump, w_grow_size};
        end
        r_rd <= r_mem[r_idx[IDX_W-1:0]];
    end

    // Growth step: size, end address and fit against limit and table
    assign w_half      = r_pool_size >> 1;
    assign w_grow_size = (r_mode == MODE_RESET) ? r_pool_size :
                         ((r_want > w_half) ? r_want : w_half);
    assign w_grow_end  = {1'b0, r_bump} + {{(ADDR_W+1-SIZE_W){1'b0}}, w_grow_size};
    assign w_grow_ok   = (r_count < CNT_W'(MAX_ENTRIES)) &&
                         (w_grow_end <= {1'b0, r_region_limit});
    assign w_scan_more = (r_idx < r_count);

    bfp_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_scan_ctl),
        .i_idx       (r_cmp_idx),
        .i_base      (r_rd[ENT_W-1:SIZE_W]),
        .i_size      (r_rd[SIZE_W-1:0]),
        .i_want      (r_want),
        .i_addr      (r_addr),
        .o_found     (w_found),
        .o_pick_idx  (w_pick_idx),
        .o_pick_base (w_pick_base),
        .o_pick_size (w_pick_size)
    );

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_busy     = r_busy;
        n_count    = r_count;
        n_bump     = r_bump;
        n_total    = r_total;
        n_used     = r_used;
        n_free     = r_free;
        n_grants   = r_grants;
        n_releases = r_releases;
        n_granted  = r_granted;
        n_status   = r_status;
        n_m_valid  = r_m_valid && !i_m_axis_tready;
        n_m_data   = r_m_data;
        w_mem_we   = 1'b0;
        o_s_axis_tready      = 1'b0;
        w_scan_ctl.clear     = 1'b0;
        w_scan_ctl.cmp_vld   = r_cmp_vld;
        w_scan_ctl.cmp_busy  = r_busy[r_cmp_idx];
        w_scan_ctl.free_mode = (r_mode == MODE_FREE);

        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (w_s_accept) begin
                    n_idx            = '0;
                    n_granted        = '0;
                    w_scan_ctl.clear = 1'b1;
                    case (i_s_axis_tdata[MODE_W-1:0])
                        MODE_ALLOC, MODE_FREE: begin
                            n_state = S_SCAN;
                        end
                        MODE_RESET: begin
                            n_busy  = '0;
                            n_count = '0;
                            n_total = '0;
                            n_used  = '0;
                            n_free  = '0;
                            n_bump  = r_region_base;
                            n_state = S_GROW;
                        end
                        default: begin
                            n_status = ST_UNKNOWN;
                            n_state  = S_OUT;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue one read per cycle, compare it the cycle after
                if (w_scan_more) begin
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                end else if (!r_cmp_vld) begin
                    if (r_mode == MODE_FREE) begin
                        n_state = S_FREE;
                    end else if (w_found) begin
                        n_state = S_TAKE;
                    end else begin
                        n_state = S_GROW;
                    end
                end
            end

            S_GROW: begin
                // Append one block from the bump pointer
                if (w_grow_ok) begin
                    w_mem_we = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_bump   = w_grow_end[ADDR_W-1:0];
                    n_total  = r_total + ADDR_W'(w_grow_size);
                    if (r_mode == MODE_RESET) begin
                        n_free   = r_free + ADDR_W'(w_grow_size);
                        n_status = ST_REUSED;
                    end else begin
                        // The new block is the only fit: take it at once
                        n_busy[r_count[IDX_W-1:0]] = 1'b1;
                        n_used    = r_used + ADDR_W'(w_grow_size);
                        n_grants  = r_grants + 1'b1;
                        n_granted = r_bump;
                        n_status  = ST_GROWN;
                    end
                end else begin
                    n_status = ST_NO_SPACE;
                end
                n_state = S_OUT;
            end

            S_TAKE: begin
                n_busy[w_pick_idx] = 1'b1;
                n_used    = r_used + ADDR_W'(w_pick_size);
                n_free    = r_free - ADDR_W'(w_pick_size);
                n_grants  = r_grants + 1'b1;
                n_granted = w_pick_base;
                n_status  = ST_REUSED;
                n_state   = S_OUT;
            end

            S_FREE: begin
                if (w_found) begin
                    n_busy[w_pick_idx] = 1'b0;
                    n_used     = r_used - ADDR_W'(w_pick_size);
                    n_free     = r_free + ADDR_W'(w_pick_size);
                    n_releases = r_releases + 1'b1;
                    n_status   = ST_FREED;
                end else begin
                    n_status = ST_UNKNOWN;
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                // Load the result once the output register is free
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{PAD_W{1'b0}}, r_releases, r_grants, r_free, r_used,
                                 r_total, r_status, r_granted};
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and pool registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_busy     <= '0;
            r_count    <= '0;
            r_bump     <= '0;
            r_total    <= '0;
            r_used     <= '0;
            r_free     <= '0;
            r_grants   <= '0;
            r_releases <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_busy     <= n_busy;
            r_count    <= n_count;
            r_bump     <= n_bump;
            r_total    <= n_total;
            r_used     <= n_used;
            r_free     <= n_free;
            r_grants   <= n_grants;
            r_releases <= n_releases;
            r_m_valid  <= n_m_valid;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_granted <= n_granted;
        r_status  <= n_status;
        r_m_data  <= n_m_data;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    // Every byte in the pool is either used or free
    a_sum_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == ADDR_W'(r_used + r_free))
        else $error("pool byte totals out of balance");

    // Table fill never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    // An accepted request blocks the input until its result is formed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept |=> !o_s_axis_tready)
        else $error("request taken while another is in flight");

    // Each result loaded in the output step is presented on the master stream
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && n_state == S_IDLE) |=> r_m_valid)
        else $error("result not presented");
`endif

endmodule

// File: src/bfp_scan.sv
// ----------------------------------------------------------------------------
// bfp_scan
// Compare unit of the table search. Looks at one entry per cycle and keeps
// the best pick so far: smallest free block that fits (first on a tie), or
// the first busy block with a matching base.
// ----------------------------------------------------------------------------
module bfp_scan #(
    parameter int IDX_W = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bfp_pkg::t_scan_ctl     i_ctl,
    input  logic [IDX_W-1:0]       i_idx,
    input  logic [bfp_pkg::ADDR_W-1:0] i_base,
    input  logic [bfp_pkg::SIZE_W-1:0] i_size,
    input  logic [bfp_pkg::SIZE_W-1:0] i_want,
    input  logic [bfp_pkg::ADDR_W-1:0] i_addr,
    output logic                   o_found,
    output logic [IDX_W-1:0]       o_pick_idx,
    output logic [bfp_pkg::ADDR_W-1:0] o_pick_base,
    output logic [bfp_pkg::SIZE_W-1:0] o_pick_size
);
    import bfp_pkg::*;

    logic              r_found;
    logic [IDX_W-1:0]  r_pick_idx;
    logic [ADDR_W-1:0] r_pick_base;
    logic [SIZE_W-1:0] r_pick_size;
    logic              w_fit;
    logic              w_hit;
    logic              w_take;

    // Match rules for the two search kinds
    assign w_fit  = !i_ctl.cmp_busy && (i_size >= i_want) &&
                    (!r_found || (i_size < r_pick_size));
    assign w_hit  = i_ctl.cmp_busy && (i_base == i_addr) && !r_found;
    assign w_take = i_ctl.cmp_vld && (i_ctl.free_mode ? w_hit : w_fit);

    // Hold the found flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    // Capture the pick
    always_ff @(posedge i_clk) begin
        if (w_take && !i_ctl.clear) begin
            r_pick_idx  <= i_idx;
            r_pick_base <= i_base;
            r_pick_size <= i_size;
        end
    end

    assign o_found     = r_found;
    assign o_pick_idx  = r_pick_idx;
    assign o_pick_base = r_pick_base;
    assign o_pick_size = r_pick_size;

endmodule
